>>> rtl/bbd_pkg.sv
// Shared types and constants of the bilinear Bayer demosaic block.
// Holds the input and output word layouts, the 3x3 window type and the per-pixel controls.
// No dependencies.
package bbd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int SAMPLE_W   = 16;
	localparam int DIM_W      = 13;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Color site of a pixel, coded as {row odd, column odd}.
	localparam logic [1:0] SITE_R  = 2'b00;
	localparam logic [1:0] SITE_GR = 2'b01;
	localparam logic [1:0] SITE_GB = 2'b10;
	localparam logic [1:0] SITE_B  = 2'b11;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t sample;
		logic    pad;
	} in_word_t;

	typedef struct packed {
		sample_t red;
		sample_t green;
		sample_t blue;
		logic    frame_end;
	} out_word_t;

	// Window indexed [row][column]: row 0 is the upper line, column 2 the newest.
	typedef logic [2:0][2:0][SAMPLE_W-1:0] win_t;

	// Border and site information for one pixel computation.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic y_odd;
		logic x_odd;
		logic last;
	} pix_ctl_t;

endpackage

>>> rtl/bbd_pixel.sv
// Bilinear interpolation of one RGGB pixel from a 3x3 window.
// Zeroes out-of-frame neighbors and averages with truncation. Depends on bbd_pkg.
module bbd_pixel (
	input  bbd_pkg::win_t      win,
	input  bbd_pkg::pix_ctl_t  ctl,
	output bbd_pkg::out_word_t px
);
	import bbd_pkg::*;

	win_t              v;
	logic [SAMPLE_W+1:0] cross_sum;
	logic [SAMPLE_W+1:0] corner_sum;
	logic [SAMPLE_W:0]   horiz_sum;
	logic [SAMPLE_W:0]   vert_sum;
	sample_t           cross_avg;
	sample_t           corner_avg;
	sample_t           horiz_avg;
	sample_t           vert_avg;

	always_comb begin
		v = win;
		for (int k = 0; k < 3; k++) begin
			if (ctl.top) v[0][k] = '0;
			if (ctl.bottom) v[2][k] = '0;
			if (ctl.left) v[k][0] = '0;
			if (ctl.right) v[k][2] = '0;
		end
	end

	assign cross_sum  = (SAMPLE_W+2)'(v[1][0]) + (SAMPLE_W+2)'(v[1][2])
		+ (SAMPLE_W+2)'(v[0][1]) + (SAMPLE_W+2)'(v[2][1]);
	assign corner_sum = (SAMPLE_W+2)'(v[0][0]) + (SAMPLE_W+2)'(v[0][2])
		+ (SAMPLE_W+2)'(v[2][0]) + (SAMPLE_W+2)'(v[2][2]);
	assign horiz_sum  = (SAMPLE_W+1)'(v[1][0]) + (SAMPLE_W+1)'(v[1][2]);
	assign vert_sum   = (SAMPLE_W+1)'(v[0][1]) + (SAMPLE_W+1)'(v[2][1]);

	assign cross_avg  = cross_sum[SAMPLE_W+1:2];
	assign corner_avg = corner_sum[SAMPLE_W+1:2];
	assign horiz_avg  = horiz_sum[SAMPLE_W:1];
	assign vert_avg   = vert_sum[SAMPLE_W:1];

	always_comb begin
		px.frame_end = ctl.last;
		unique case ({ctl.y_odd, ctl.x_odd})
			SITE_R: begin
				px.red   = v[1][1];
				px.green = cross_avg;
				px.blue  = corner_avg;
			end
			SITE_GR: begin
				px.green = v[1][1];
				px.red   = horiz_avg;
				px.blue  = vert_avg;
			end
			SITE_GB: begin
				px.green = v[1][1];
				px.red   = vert_avg;
				px.blue  = horiz_avg;
			end
			default: begin
				px.blue  = v[1][1];
				px.green = cross_avg;
				px.red   = corner_avg;
			end
		endcase
	end

endmodule

>>> rtl/bayer_bilinear_demosaic.sv
// Top level of the bilinear RGGB demosaic: line stores, window, counters and output queue.
// Depends on bbd_pkg and bbd_pixel.
//
// Throughput: one word per cycle; the input stalls only while the output queue holds
// three or more words. An accepted word passes the stage-one registers and the window
// register before its results enter the output queue. The async reset clears counters,
// window, queue and registers; the line stores are not cleared and need no clearing pass.
module bayer_bilinear_demosaic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bbd_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bbd_pkg::out_word_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bbd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bbd_pkg::DIM_W-1:0]           cfg_data
);
	import bbd_pkg::*;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Controls that travel with a word through the two stages.
	typedef struct packed {
		logic     emit_a;
		logic     emit_b;
		pix_ctl_t a;
		pix_ctl_t b;
	} stage_ctl_t;

	function automatic logic [DIM_W:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W:0] maxv);
		logic [DIM_W:0] r;
		begin
			r = {1'b0, v};
			if (v < DIM_W'(2)) r = (DIM_W+1)'(2);
			else if ({1'b0, v} > maxv) r = maxv;
			return r;
		end
	endfunction

	// Configuration. Writes are only expected while the block is idle, so they are
	// always taken at once. The width is kept as its last column index.
	logic [COL_W-1:0] wm1_q;
	logic [ROW_W-1:0] h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= COL_W'(MAX_WIDTH - 1);
			h_q   <= ROW_W'(MAX_HEIGHT);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: begin
					wm1_q <= COL_W'(clamp_dim(cfg_data, (DIM_W+1)'(MAX_WIDTH)) - 1'b1);
				end
				REG_FRAME_HEIGHT: begin
					h_q <= ROW_W'(clamp_dim(cfg_data, (DIM_W+1)'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline moves together; it holds only when the output queue could
	// not take the two words that the end of a row may produce.
	logic [CNT_W-1:0] cnt_q;
	logic             adv;
	logic             acc;

	assign adv      = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// Front end: position of the incoming word. A column count beyond a narrowed
	// width is treated as the last column.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] c_eff;
	logic             last_col;
	logic             has_row;
	sample_t          s_in;
	stage_ctl_t       ctl_in;

	assign c_eff    = (col_q > wm1_q) ? wm1_q : col_q;
	assign last_col = c_eff == wm1_q;
	assign has_row  = row_q != '0;
	assign s_in     = in_data.pad ? '0 : in_data.sample;

	always_comb begin
		ctl_in.emit_a = has_row && (c_eff != '0);
		ctl_in.emit_b = has_row && last_col;
		// Pixel one column back from the incoming word, one row up.
		ctl_in.a.top    = row_q == ROW_W'(1);
		ctl_in.a.bottom = row_q >= h_q;
		ctl_in.a.left   = c_eff == COL_W'(1);
		ctl_in.a.right  = 1'b0;
		ctl_in.a.y_odd  = ~row_q[0];
		ctl_in.a.x_odd  = ~c_eff[0];
		ctl_in.a.last   = 1'b0;
		// Pixel in the last column, computed from the window shifted once more.
		ctl_in.b.top    = ctl_in.a.top;
		ctl_in.b.bottom = ctl_in.a.bottom;
		ctl_in.b.left   = 1'b0;
		ctl_in.b.right  = 1'b1;
		ctl_in.b.y_odd  = ~row_q[0];
		ctl_in.b.x_odd  = c_eff[0];
		ctl_in.b.last   = row_q == h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_q >= h_q) ? '0 : ROW_W'(row_q + 1'b1);
			end else begin
				col_q <= COL_W'(c_eff + 1'b1);
			end
		end
	end

	// Line stores. The middle line is read and overwritten with the new sample at
	// acceptance; the upper line is read then and written from the stage-one registers
	// with the old middle value. Consecutive words always address different columns, and a
	// word reaches the same column only after the earlier write has landed.
	sample_t          upper_mem [MAX_WIDTH];
	sample_t          middle_mem [MAX_WIDTH];
	sample_t          up_rd_s1;
	sample_t          mid_rd_s1;
	sample_t          sample_s1;
	logic [COL_W-1:0] col_s1;
	stage_ctl_t       ctl_s1;
	logic             vld_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			mid_rd_s1          <= middle_mem[c_eff];
			middle_mem[c_eff]  <= s_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			up_rd_s1 <= upper_mem[c_eff];
		end
		if (adv && vld_s1) begin
			upper_mem[col_s1] <= mid_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sample_s1 <= s_in;
			col_s1    <= c_eff;
			ctl_s1    <= ctl_in;
		end
	end

	// Window: shifts once per word, the new column coming from the line stores and the incoming sample.
	win_t       win_q;
	stage_ctl_t ctl_s2;
	logic       vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up_rd_s1;
				win_q[1][2] <= mid_rd_s1;
				win_q[2][2] <= sample_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Pixel units: one for the regular result, one for the extra last-column result.
	win_t      win_tail;
	out_word_t px_a;
	out_word_t px_b;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_tail[r][0] = win_q[r][1];
			win_tail[r][1] = win_q[r][2];
			win_tail[r][2] = '0;
		end
	end

	bbd_pixel u_pix_a (
		.win (win_q),
		.ctl (ctl_s2.a),
		.px  (px_a)
	);

	bbd_pixel u_pix_b (
		.win (win_tail),
		.ctl (ctl_s2.b),
		.px  (px_b)
	);

	// Output queue. Up to two words enter per cycle, in pixel order.
	out_word_t        fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [1:0]       push_n;
	logic             pop;
	out_word_t        first_word;

	assign push_n     = (adv && vld_s2) ? ({1'b0, ctl_s2.emit_a} + {1'b0, ctl_s2.emit_b}) : 2'd0;
	assign pop        = out_valid && !out_stall;
	assign first_word = ctl_s2.emit_a ? px_a : px_b;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wptr_q] <= first_word;
		end
		if (push_n == 2'd2) begin
			fifo_q[PTR_W'(wptr_q + 1'b1)] <= px_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= PTR_W'(wptr_q + PTR_W'(push_n));
			rptr_q <= PTR_W'(rptr_q + PTR_W'(pop));
			cnt_q  <= CNT_W'(cnt_q + CNT_W'(push_n) - CNT_W'(pop));
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_q[rptr_q];

endmodule

>>> rtl/bbd_checker.sv
// Port-level checks of the bilinear demosaic block, attached by bind.
// Depends on bbd_pkg and the top level bayer_bilinear_demosaic.
module bbd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input bbd_pkg::out_word_t out_data
);
	import bbd_pkg::*;

	// A waiting word stays and holds its value while the receiver stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output word dropped or changed under stall");

	// With nothing queued the block must take input.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output queue");

	// Two frame-end words are never shown back to back: a taken frame-end word is not directly followed by another.
	a_frame_end_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.frame_end
		|=> !(out_valid && out_data.frame_end))
		else $error("two frame-end words in a row");

	// Reset empties the output queue.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word shown during reset");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tb_top.sv
// Self-checking testbench for bayer_bilinear_demosaic, the RGGB bilinear demosaic block.
// Depends on bbd_pkg for the word layouts, register indexes and color site codes.
// Drives words with random gaps and stalls and checks every pixel against its own predictor.
module tb_top;
	import bbd_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 100000;
	localparam int TIMEOUT_CYCLES = 1500000;

	logic                 clk;
	logic                 arst_n    = 1'b1;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_WIDTH;
	logic [DIM_W-1:0]     cfg_data  = '0;

	bayer_bilinear_demosaic u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Idle rates in percent of cycles for the sending and the receiving side.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_sent    = 0;
	int fail_count    = 0;

	// Predictor state. It mirrors the line stores, the 3x3 window and the raster
	// position of the block, together with the two configuration registers as written.
	sample_t          upper_store [MAX_WIDTH];
	sample_t          middle_store [MAX_WIDTH];
	win_t             win        = '0;
	int               col_pos    = 0;
	int               row_pos    = 0;
	logic [DIM_W-1:0] width_reg  = 13'd4096;
	logic [DIM_W-1:0] height_reg = 13'd4096;
	out_word_t        expected_pixels [$];

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Safety net: a hung handshake or a lost pixel ends the run here.
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("tb: failure");
		$finish;
	end

	function automatic int clamp_dim(int v, int maxv);
		if (v < 2)
			return 2;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Colors of the pixel at row y, column x from its neighborhood nb. Neighbors that
	// fall outside the frame are forced to zero by position, but the divisors stay fixed,
	// so border pixels come out darker. All averages truncate.
	function automatic out_word_t bilinear_pixel(win_t nb, int y, int x, int w, int h);
		int         v [3][3];
		int         cross_val, corner, horiz, vert;
		logic [1:0] site;
		out_word_t  px;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				v[i][j] = int'(nb[i][j]);
		for (int k = 0; k < 3; k++) begin
			if (y == 0)
				v[0][k] = 0;
			if (y + 1 >= h)
				v[2][k] = 0;
			if (x == 0)
				v[k][0] = 0;
			if (x + 1 >= w)
				v[k][2] = 0;
		end
		cross_val = (v[1][0] + v[1][2] + v[0][1] + v[2][1]) >> 2;
		corner    = (v[0][0] + v[0][2] + v[2][0] + v[2][2]) >> 2;
		horiz     = (v[1][0] + v[1][2]) >> 1;
		vert      = (v[0][1] + v[2][1]) >> 1;
		site = {y[0], x[0]};
		unique case (site)
			SITE_R: begin
				px.red   = sample_t'(v[1][1]);
				px.green = sample_t'(cross_val);
				px.blue  = sample_t'(corner);
			end
			SITE_GR: begin
				px.green = sample_t'(v[1][1]);
				px.red   = sample_t'(horiz);
				px.blue  = sample_t'(vert);
			end
			SITE_GB: begin
				px.green = sample_t'(v[1][1]);
				px.red   = sample_t'(vert);
				px.blue  = sample_t'(horiz);
			end
			SITE_B: begin
				px.blue  = sample_t'(v[1][1]);
				px.green = sample_t'(cross_val);
				px.red   = sample_t'(corner);
			end
		endcase
		px.frame_end = (y == h - 1) && (x == w - 1);
		return px;
	endfunction

	// Advances the predictor by one accepted word and queues the pixels it releases.
	// Output lags the input by one row and one column; the word in the last column
	// also releases the last pixel of the row above, whose right neighbors are zero.
	function automatic void interpolate_word(in_word_t wd);
		int      w, h, c;
		sample_t s;
		win_t    tail;
		w = clamp_dim(int'(width_reg), MAX_WIDTH);
		h = clamp_dim(int'(height_reg), MAX_HEIGHT);
		s = wd.pad ? '0 : wd.sample;
		c = col_pos;
		// After the width shrinks mid-frame, a stale column counts as the last one.
		if (c > w - 1)
			c = w - 1;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = upper_store[c];
		win[1][2] = middle_store[c];
		win[2][2] = s;
		upper_store[c]  = middle_store[c];
		middle_store[c] = s;
		if (row_pos >= 1 && c >= 1)
			expected_pixels.push_back(bilinear_pixel(win, row_pos - 1, c - 1, w, h));
		if (row_pos >= 1 && c == w - 1) begin
			for (int k = 0; k < 3; k++) begin
				tail[k][0] = win[k][1];
				tail[k][1] = win[k][2];
				tail[k][2] = '0;
			end
			expected_pixels.push_back(bilinear_pixel(tail, row_pos - 1, c, w, h));
		end
		if (c == w - 1) begin
			col_pos = 0;
			// The row counter runs one past the frame for the padding row, then wraps.
			row_pos = (row_pos >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic check_field(string name, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_pixel(out_word_t got);
		out_word_t want;
		if (expected_pixels.size() == 0) begin
			fail_count++;
			$display("%0t: pixel with none expected, expected nothing actual %h",
				$time, got);
		end else begin
			want = expected_pixels.pop_front();
			check_field("red", want.red, got.red);
			check_field("green", want.green, got.green);
			check_field("blue", want.blue, got.blue);
			check_field("frame_end", SAMPLE_W'(want.frame_end), SAMPLE_W'(got.frame_end));
		end
	endtask

	// Outputs are sampled at the rising edge; out_stall only changes at the falling edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_pixel(out_data);
	end

	// The receiving side stalls at random; at zero percent it never stalls.
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Sends one word. The idle gap comes first, so valid is only dropped while idling
	// and a word that follows directly keeps valid high across the boundary.
	task automatic send_word(in_word_t wd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= wd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		interpolate_word(wd);
		words_sent++;
	endtask

	// Holds the input off until every expected pixel has come out, then lets the
	// pipeline settle, since a word in the top row leaves nothing behind to wait for.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_ROW_WIDTH)
			width_reg = value;
		else if (idx == REG_FRAME_HEIGHT)
			height_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic sample_t random_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return sample_t'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Most widths are small to keep frames short; a few fall below the legal range.
	function automatic logic [DIM_W-1:0] pick_width();
		int p;
		p = $urandom_range(99);
		if (p < 75)
			return DIM_W'($urandom_range(12, 2));
		if (p < 93)
			return DIM_W'($urandom_range(80, 13));
		return DIM_W'($urandom_range(1, 0));
	endfunction

	function automatic logic [DIM_W-1:0] pick_height();
		int p;
		p = $urandom_range(99);
		if (p < 80)
			return DIM_W'($urandom_range(8, 2));
		if (p < 92)
			return DIM_W'($urandom_range(20, 9));
		return DIM_W'($urandom_range(1, 0));
	endfunction

	// Sends random words until the raster position reaches the goal. Words in the
	// padding row mostly carry the pad flag; the rest test the position-only rule.
	task automatic send_until(int row_goal, int col_goal, int pad_pct);
		in_word_t wd;
		do begin
			wd.sample = random_sample();
			if (row_pos >= clamp_dim(int'(height_reg), MAX_HEIGHT))
				wd.pad = ($urandom_range(99) < 85);
			else
				wd.pad = ($urandom_range(99) < pad_pct);
			send_word(wd);
		end while (row_pos != row_goal || col_pos != col_goal);
	endtask

	// With only the height written, the first row runs at the reset width of 4096.
	// A narrower width written partway through that row ends it at the next word.
	// A height of one is below the legal range and must act as two.
	task automatic test_reset_width();
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		send_until(0, 150, 2);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd8);
		send_until(0, 0, 2);
	endtask

	// Full-scale and alternating-bit samples over all four color sites.
	task automatic test_sample_extremes();
		in_word_t wd;
		sample_t  levels [4] = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd2);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		// Full scale everywhere, padding row included but without the pad flag:
		// no sum may wrap, and the row below the frame must still read as zero.
		repeat (6) begin
			wd.sample = '1;
			wd.pad    = 1'b0;
			send_word(wd);
		end
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		// One flagged word sits inside the frame; the padding row mixes the flag.
		for (int i = 0; i < 20; i++) begin
			wd.sample = levels[(i + i / 4) % 4];
			wd.pad    = (i == 5) || (i >= 16 && i[0]);
			send_word(wd);
		end
	endtask

	// Register values outside the legal range, and odd frame sizes.
	task automatic test_register_clamp();
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		send_until(0, 0, 0);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		send_until(0, 0, 10);
	endtask

	// Registers rewritten inside a frame take effect at once.
	task automatic test_midframe_writes();
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd6);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		// The column counter already stands beyond the new last column.
		send_until(2, 4, 0);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd3);
		// After the height write below, the current row lies below the frame: it still emits, with no
		// bottom neighbors and no frame_end, and then wraps to the top.
		send_until(3, 1, 0);
		wait_quiet();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_until(0, 0, 0);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		// Growing the height mid-frame moves the last row further down.
		send_until(1, 2, 0);
		wait_quiet();
		write_reg(REG_FRAME_HEIGHT, 13'd5);
		send_until(0, 0, 0);
	endtask

	// The largest sizes, the height exact and clamped and the width clamped, each paired with the smallest other size.
	// Each frame is entered at the large size and then cut short by a smaller value
	// written between words, so that the frames stay short.
	task automatic test_large_frames();
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd2);
		write_reg(REG_FRAME_HEIGHT, 13'd4096);
		send_until(6, 0, 1);
		wait_quiet();
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		send_until(0, 0, 1);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd8191);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		send_until(0, 120, 1);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd5);
		send_until(0, 0, 1);
		wait_quiet();
		write_reg(REG_ROW_WIDTH, 13'd1);
		write_reg(REG_FRAME_HEIGHT, 13'd8191);
		send_until(9, 0, 1);
		wait_quiet();
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		send_until(0, 0, 1);
	endtask

	// Whole frames with random content. Half the frames get a new geometry after the
	// output drains; others follow back to back. Now and then a register changes
	// inside a frame: the width only shrinks there, so no unwritten line entry is read.
	task automatic run_random(int word_goal);
		int start, w, h;
		start = words_sent;
		while (words_sent - start < word_goal) begin
			if ($urandom_range(1)) begin
				wait_quiet();
				write_reg(REG_ROW_WIDTH, pick_width());
				write_reg(REG_FRAME_HEIGHT, pick_height());
			end
			if ($urandom_range(9) == 0) begin
				w = clamp_dim(int'(width_reg), MAX_WIDTH);
				h = clamp_dim(int'(height_reg), MAX_HEIGHT);
				send_until($urandom_range(h - 1, 1), $urandom_range(w - 1, 0), 3);
				wait_quiet();
				if (w > 2 && $urandom_range(1))
					write_reg(REG_ROW_WIDTH, DIM_W'($urandom_range(w - 1, 2)));
				else
					write_reg(REG_FRAME_HEIGHT, pick_height());
			end
			send_until(0, 0, 3);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender idles a little while the receiver stalls most of the time.
		send_idle_pct = 20;
		recv_idle_pct = 76;
		test_reset_width();
		test_sample_extremes();
		test_register_clamp();
		test_midframe_writes();
		run_random(450);

		// The other way round: a sparse sender and a mostly ready receiver.
		send_idle_pct = 76;
		recv_idle_pct = 20;
		test_large_frames();
		run_random(450);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(450);

		@(negedge clk);
		in_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES)
			@(posedge clk);
		if (expected_pixels.size() != 0) begin
			fail_count += expected_pixels.size();
			$display("%0t: %0d expected pixels never came out, first expected %h actual none",
				$time, expected_pixels.size(), expected_pixels[0]);
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
